### rtl/rae_pkg.sv
// Shared types and constants of the RV32I register-register execute block.
// Used by every module in this folder but rae_ram; it depends on nothing else.
`default_nettype none

package rae_pkg;

  localparam int XLEN   = 32;
  localparam int NREGS  = 32;
  localparam int REG_AW = $clog2(NREGS);
  localparam int SH_W   = $clog2(XLEN);

  localparam logic [6:0]      OPCODE_OP = 7'h33;
  localparam logic [XLEN-1:0] PC_STEP   = XLEN'(4);

  localparam logic CMD_EXECUTE = 1'b0;
  localparam logic CMD_PRELOAD = 1'b1;

  typedef enum logic [2:0] {
    F3_ADD_SUB = 3'b000,
    F3_SLL     = 3'b001,
    F3_SLT     = 3'b010,
    F3_SLTU    = 3'b011,
    F3_XOR     = 3'b100,
    F3_SRL_SRA = 3'b101,
    F3_OR      = 3'b110,
    F3_AND     = 3'b111
  } funct3_t;

  // One request as it enters the block.
  typedef struct packed {
    logic              command;
    logic [XLEN-1:0]   instruction_word;
    logic [XLEN-1:0]   program_counter;
    logic [REG_AW-1:0] preload_index;
    logic [XLEN-1:0]   preload_value;
  } rae_req_t;

  // One register file write.
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] idx;
    logic [XLEN-1:0]   data;
  } rae_wr_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic [REG_AW-1:0] dest_index;
    logic [XLEN-1:0]   written_value;
    logic              illegal;
  } rae_res_t;

endpackage

`default_nettype wire

### rtl/rae_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; it uses no package.
`default_nettype none

module rae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/rae_regfile.sv
// Register file with two read ports: two RAM copies written together, valid
// bits that make unwritten entries read as zero, and a bypass of the last write.
// Depends on rae_pkg and rae_ram.
`default_nettype none

module rae_regfile (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [rae_pkg::REG_AW-1:0] rs1_addr,
  input  wire logic [rae_pkg::REG_AW-1:0] rs2_addr,
  input  wire rae_pkg::rae_wr_t           wr,
  output      logic [rae_pkg::XLEN-1:0]   rs1_data,
  output      logic [rae_pkg::XLEN-1:0]   rs2_data
);
  import rae_pkg::*;

  logic [NREGS-1:0]  valid_bits;
  logic [REG_AW-1:0] rs1_addr_q;
  logic [REG_AW-1:0] rs2_addr_q;
  logic              rs1_vld_q;
  logic              rs2_vld_q;
  logic [XLEN-1:0]   rs1_ram;
  logic [XLEN-1:0]   rs2_ram;
  rae_wr_t           last_wr;

  rae_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_ram_a (
    .clk    (clk),
    .wr_en  (wr.en),
    .wr_addr(wr.idx),
    .wr_data(wr.data),
    .rd_en  (rd_en),
    .rd_addr(rs1_addr),
    .rd_data(rs1_ram)
  );

  rae_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_ram_b (
    .clk    (clk),
    .wr_en  (wr.en),
    .wr_addr(wr.idx),
    .wr_data(wr.data),
    .rd_en  (rd_en),
    .rd_addr(rs2_addr),
    .rd_data(rs2_ram)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (wr.en) begin
      valid_bits[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rs1_addr_q <= rs1_addr;
      rs2_addr_q <= rs2_addr;
      rs1_vld_q  <= valid_bits[rs1_addr];
      rs2_vld_q  <= valid_bits[rs2_addr];
    end
  end

  // The most recent write always holds the current value of its register,
  // so it also covers a write that lands on the same edge as the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_wr.en <= 1'b0;
    end else if (wr.en) begin
      last_wr.en <= 1'b1;
    end
    if (wr.en) begin
      last_wr.idx  <= wr.idx;
      last_wr.data <= wr.data;
    end
  end

  always_comb begin
    if (rs1_addr_q == '0) begin
      rs1_data = '0;
    end else if (last_wr.en && (last_wr.idx == rs1_addr_q)) begin
      rs1_data = last_wr.data;
    end else if (rs1_vld_q) begin
      rs1_data = rs1_ram;
    end else begin
      rs1_data = '0;
    end

    if (rs2_addr_q == '0) begin
      rs2_data = '0;
    end else if (last_wr.en && (last_wr.idx == rs2_addr_q)) begin
      rs2_data = last_wr.data;
    end else if (rs2_vld_q) begin
      rs2_data = rs2_ram;
    end else begin
      rs2_data = '0;
    end
  end

endmodule

`default_nettype wire

### rtl/rae_alu.sv
// Decode and ALU: turns one request and its operands into a result and a
// register file write. Depends on rae_pkg.
`default_nettype none

module rae_alu (
  input  wire rae_pkg::rae_req_t        req,
  input  wire logic [rae_pkg::XLEN-1:0] rs1_data,
  input  wire logic [rae_pkg::XLEN-1:0] rs2_data,
  output      rae_pkg::rae_res_t        res,
  output      rae_pkg::rae_wr_t         wr
);
  import rae_pkg::*;

  logic [REG_AW-1:0] rd;
  logic              alt;
  logic [SH_W-1:0]   shamt;
  logic              is_op;
  logic [XLEN-1:0]   alu_out;

  assign rd    = req.instruction_word[11:7];
  assign alt   = req.instruction_word[30];
  assign shamt = rs2_data[SH_W-1:0];
  assign is_op = (req.instruction_word[6:0] == OPCODE_OP);

  always_comb begin
    case (funct3_t'(req.instruction_word[14:12]))
      F3_ADD_SUB: alu_out = alt ? (rs1_data - rs2_data) : (rs1_data + rs2_data);
      F3_SLL:     alu_out = rs1_data << shamt;
      F3_SLT:     alu_out = {{(XLEN-1){1'b0}}, ($signed(rs1_data) < $signed(rs2_data))};
      F3_SLTU:    alu_out = {{(XLEN-1){1'b0}}, (rs1_data < rs2_data)};
      F3_XOR:     alu_out = rs1_data ^ rs2_data;
      F3_SRL_SRA: alu_out = alt ? XLEN'($signed(rs1_data) >>> shamt) : (rs1_data >> shamt);
      F3_OR:      alu_out = rs1_data | rs2_data;
      F3_AND:     alu_out = rs1_data & rs2_data;
      default:    alu_out = '0;
    endcase
  end

  always_comb begin
    if (req.command == CMD_PRELOAD) begin
      wr.en             = (req.preload_index != '0);
      wr.idx            = req.preload_index;
      wr.data           = req.preload_value;
      res.next_pc       = '0;
      res.dest_index    = req.preload_index;
      res.written_value = wr.en ? req.preload_value : '0;
      res.illegal       = 1'b0;
    end else if (!is_op) begin
      wr.en             = 1'b0;
      wr.idx            = rd;
      wr.data           = alu_out;
      res.next_pc       = req.program_counter + PC_STEP;
      res.dest_index    = '0;
      res.written_value = '0;
      res.illegal       = 1'b1;
    end else begin
      wr.en             = (rd != '0);
      wr.idx            = rd;
      wr.data           = alu_out;
      res.next_pc       = req.program_counter + PC_STEP;
      res.dest_index    = rd;
      res.written_value = wr.en ? alu_out : '0;
      res.illegal       = 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/rv32i_register_alu_execute.sv
// Top level of the RV32I register-register execute block.
// Depends on rae_pkg, rae_regfile (with rae_ram) and rae_alu.
`default_nettype none

// Executes RV32I OP instructions (add, sub, sll, slt, sltu, xor, srl, sra,
// or, and) against a 32 x 32-bit register file, or preloads one register.
// Every request gives exactly one result, in order. The block takes one
// request per cycle as long as the result side keeps taking results; an
// accepted request is held in the execute stage until the result register
// takes its result. The registered read of the register file RAM
// happens on the accepting edge, beside the request register, and the ALU
// then feeds the result register. A dependent instruction may follow
// directly: the last register write is bypassed to the operand path. Register
// x0 reads as zero and is never written. After reset every register reads as
// zero without any clearing pass, since per-register valid bits are cleared
// at once. An opcode other than OP gives a result with illegal set, no write,
// dest_index and written_value of zero, and next_pc = program_counter + 4. A
// preload request returns next_pc of zero, the preloaded register number and
// the value that register now holds. Both channels use valid and ready;
// request_ready is low during reset.

module rv32i_register_alu_execute (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       request_valid,
  output      logic                       request_ready,
  input  wire logic                       command,
  input  wire logic [rae_pkg::XLEN-1:0]   instruction_word,
  input  wire logic [rae_pkg::XLEN-1:0]   program_counter,
  input  wire logic [rae_pkg::REG_AW-1:0] preload_index,
  input  wire logic [rae_pkg::XLEN-1:0]   preload_value,
  output      logic                       result_valid,
  input  wire logic                       result_ready,
  output      logic [rae_pkg::XLEN-1:0]   next_pc,
  output      logic [rae_pkg::REG_AW-1:0] dest_index,
  output      logic [rae_pkg::XLEN-1:0]   written_value,
  output      logic                       illegal
);
  import rae_pkg::*;

  // Execute stage: the request waits here while its operands come out of
  // the RAM, and the ALU works on it.
  logic     s1_valid;
  rae_req_t s1_req;
  logic     s1_advance;
  logic     accept;

  logic [XLEN-1:0] rs1_data;
  logic [XLEN-1:0] rs2_data;
  rae_res_t        alu_res;
  rae_wr_t         alu_wr;
  rae_wr_t         rf_wr;
  rae_res_t        res_q;

  // The execute stage moves on when the result register is empty or is
  // being emptied in this cycle; a new request enters behind it.
  assign s1_advance    = !result_valid || result_ready;
  assign request_ready = !rst && (!s1_valid || s1_advance);
  assign accept        = request_valid && request_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_req.command          <= command;
      s1_req.instruction_word <= instruction_word;
      s1_req.program_counter  <= program_counter;
      s1_req.preload_index    <= preload_index;
      s1_req.preload_value    <= preload_value;
    end
  end

  // Operands are read straight from the request ports on the accepting edge.
  rae_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rs1_addr(instruction_word[19:15]),
    .rs2_addr(instruction_word[24:20]),
    .wr      (rf_wr),
    .rs1_data(rs1_data),
    .rs2_data(rs2_data)
  );

  rae_alu u_alu (
    .req     (s1_req),
    .rs1_data(rs1_data),
    .rs2_data(rs2_data),
    .res     (alu_res),
    .wr      (alu_wr)
  );

  // The register file is written on the same edge that the result is loaded.
  always_comb begin
    rf_wr    = alu_wr;
    rf_wr.en = alu_wr.en && s1_valid && s1_advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= s1_valid;
    end
    if (s1_advance && s1_valid) begin
      res_q <= alu_res;
    end
  end

  assign next_pc       = res_q.next_pc;
  assign dest_index    = res_q.dest_index;
  assign written_value = res_q.written_value;
  assign illegal       = res_q.illegal;

`ifndef SYNTH
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted request did not reach the execute stage");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> s1_valid)
    else $error("execute stage lost a stalled request");

  a_no_write_x0: assert property (@(posedge clk) disable iff (rst)
    rf_wr.en |-> (rf_wr.idx != '0))
    else $error("write to register x0");

  a_illegal_result_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && illegal) |-> ((dest_index == '0) && (written_value == '0)))
    else $error("illegal result carries a destination or a value");
`endif

endmodule

`default_nettype wire

### dv/rv32i_register_alu_execute_tb.sv
// Self-checking testbench for rv32i_register_alu_execute: directed and random
// execute and preload requests, checked against a register file mirror.
// Depends on rae_pkg and the RTL of the block.
`timescale 1ns / 1ps

module rv32i_register_alu_execute_tb;
  import rae_pkg::*;

  // Mirror of the register file plus the queue of results still owed by the
  // block. Every accepted request is turned into its result right away, so
  // the mirror always reflects the state after the last accepted request.
  class regfile_scoreboard;
    logic [XLEN-1:0] regs [NREGS];
    rae_res_t        expected_results[$];
    int              errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
    endfunction

    // Register x0 is never written in the mirror, so it always reads zero.
    function rae_res_t predict_writeback(rae_req_t r);
      rae_res_t        res;
      logic [4:0]      rd;
      logic [4:0]      sh;
      logic [XLEN-1:0] a;
      logic [XLEN-1:0] b;
      logic [XLEN-1:0] val;
      logic            alt;
      funct3_t         op;
      res = '0;
      if (r.command == CMD_PRELOAD) begin
        res.dest_index = r.preload_index;
        if (r.preload_index != '0) regs[r.preload_index] = r.preload_value;
        res.written_value = regs[r.preload_index];
      end else begin
        res.next_pc = r.program_counter + PC_STEP;
        if (r.instruction_word[6:0] != OPCODE_OP) begin
          res.illegal = 1'b1;
        end else begin
          rd  = r.instruction_word[11:7];
          op  = funct3_t'(r.instruction_word[14:12]);
          a   = regs[r.instruction_word[19:15]];
          b   = regs[r.instruction_word[24:20]];
          alt = r.instruction_word[30];
          sh  = b[4:0];
          case (op)
            F3_ADD_SUB: val = alt ? a - b : a + b;
            F3_SLL:     val = a << sh;
            F3_SLT:     val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU:    val = (a < b) ? 32'd1 : 32'd0;
            F3_XOR:     val = a ^ b;
            F3_SRL_SRA: val = alt ? XLEN'($signed(a) >>> sh) : a >> sh;
            F3_OR:      val = a | b;
            default:    val = a & b;
          endcase
          res.dest_index = rd;
          if (rd != '0) regs[rd] = val;
          res.written_value = regs[rd];
        end
      end
      return res;
    endfunction

    function void note_request(rae_req_t r);
      expected_results.push_back(predict_writeback(r));
    endfunction

    function void check_result(rae_res_t got);
      rae_res_t want;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: next_pc %h dest_index %0d",
               got.next_pc, got.dest_index);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.next_pc !== want.next_pc) begin
        $error("next_pc: expected %h, actual %h", want.next_pc, got.next_pc);
        errors++;
      end
      if (got.dest_index !== want.dest_index) begin
        $error("dest_index: expected %0d, actual %0d", want.dest_index, got.dest_index);
        errors++;
      end
      if (got.written_value !== want.written_value) begin
        $error("written_value: expected %h, actual %h", want.written_value,
               got.written_value);
        errors++;
      end
      if (got.illegal !== want.illegal) begin
        $error("illegal: expected %b, actual %b", want.illegal, got.illegal);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                clk;
  logic                rst              = 1'b1;
  logic                request_valid    = 1'b0;
  logic                request_ready;
  logic                command          = CMD_EXECUTE;
  logic [XLEN-1:0]     instruction_word = '0;
  logic [XLEN-1:0]     program_counter  = '0;
  logic [REG_AW-1:0]   preload_index    = '0;
  logic [XLEN-1:0]     preload_value    = '0;
  logic                result_valid;
  logic                result_ready     = 1'b0;
  logic [XLEN-1:0]     next_pc;
  logic [REG_AW-1:0]   dest_index;
  logic [XLEN-1:0]     written_value;
  logic                illegal;

  regfile_scoreboard sb;

  // Idle percentages of the two sides, changed by the stimulus between phases.
  int send_idle_pct     = 0;
  int recv_idle_pct     = 0;
  // A long result-side hold-off; the result sink counts it down itself.
  int hold_off_cycles   = 0;

  rv32i_register_alu_execute u_dut (
    .clk              (clk),
    .rst              (rst),
    .request_valid    (request_valid),
    .request_ready    (request_ready),
    .command          (command),
    .instruction_word (instruction_word),
    .program_counter  (program_counter),
    .preload_index    (preload_index),
    .preload_value    (preload_value),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .next_pc          (next_pc),
    .dest_index       (dest_index),
    .written_value    (written_value),
    .illegal          (illegal)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Builds an OP-format instruction word from its fields.
  function automatic logic [XLEN-1:0] make_op(logic [6:0] f7, funct3_t f3,
                                              logic [4:0] rd, logic [4:0] rs1,
                                              logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, OPCODE_OP};
  endfunction

  function automatic rae_req_t exec_req(logic [XLEN-1:0] word, logic [XLEN-1:0] pc);
    rae_req_t r;
    r.command          = CMD_EXECUTE;
    r.instruction_word = word;
    r.program_counter  = pc;
    r.preload_index    = REG_AW'($urandom());
    r.preload_value    = $urandom();
    return r;
  endfunction

  function automatic rae_req_t preload_req(logic [4:0] idx, logic [XLEN-1:0] val);
    rae_req_t r;
    r.command          = CMD_PRELOAD;
    r.instruction_word = $urandom();
    r.program_counter  = $urandom();
    r.preload_index    = idx;
    r.preload_value    = val;
    return r;
  endfunction

  // Operand values lean toward the corners of add, compare and shift.
  function automatic logic [XLEN-1:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return XLEN'($urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  // Mostly well-formed OP instructions over a register file kept busy by
  // preloads, with some raw words thrown in, most of which are not OP.
  function automatic rae_req_t random_request();
    int              kind;
    logic [6:0]      f7;
    logic [XLEN-1:0] pc;
    kind = $urandom_range(99);
    pc   = ($urandom_range(9) == 0) ? 32'hFFFF_FFFC + XLEN'($urandom_range(3))
                                    : XLEN'($urandom());
    if (kind < 25) return preload_req(REG_AW'($urandom()), pick_value());
    if (kind < 90) begin
      f7 = ($urandom_range(4) == 0) ? 7'($urandom()) : {1'b0, 1'($urandom()), 5'b0};
      return exec_req(make_op(f7, funct3_t'($urandom_range(7)), 5'($urandom()),
                              5'($urandom()), 5'($urandom())), pc);
    end
    return exec_req($urandom(), pc);
  endfunction

  // Offers one request, after a random idle gap, and holds it until the
  // block takes it. The payload stays put for the whole offer.
  task automatic send_request(rae_req_t r);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_valid    <= 1'b1;
    command          <= r.command;
    instruction_word <= r.instruction_word;
    program_counter  <= r.program_counter;
    preload_index    <= r.preload_index;
    preload_value    <= r.preload_value;
    do @(posedge clk); while (!request_ready);
    sb.note_request(r);
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic wait_drained();
    request_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(int n, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n) send_request(random_request());
  endtask

  // Result side: checks each accepted result and chooses the next ready.
  // Sampling happens at the clock edge, before any of this edge's updates.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready)
        sb.check_result('{next_pc: next_pc, dest_index: dest_index,
                          written_value: written_value, illegal: illegal});
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    rae_req_t directed[$];
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Operand corners are preloaded first, including the
    // highest register index and a preload of x0, which must read back zero.
    directed.push_back(preload_req(5'd1, 32'hFFFF_FFFF));
    directed.push_back(preload_req(5'd2, 32'h8000_0000));
    directed.push_back(preload_req(5'd3, 32'h7FFF_FFFF));
    directed.push_back(preload_req(5'd31, 32'h0000_0001));
    directed.push_back(preload_req(5'd0, 32'hFFFF_FFFF));
    // One of each operation, using the corner values; x1 also gives a
    // shift amount of 31.
    directed.push_back(exec_req(make_op(7'h00, F3_ADD_SUB, 5'd4, 5'd1, 5'd3), 32'h0));
    directed.push_back(exec_req(make_op(7'h20, F3_ADD_SUB, 5'd5, 5'd2, 5'd31), 32'h4));
    directed.push_back(exec_req(make_op(7'h00, F3_SLL, 5'd6, 5'd31, 5'd1), 32'h8));
    directed.push_back(exec_req(make_op(7'h00, F3_SLT, 5'd7, 5'd2, 5'd31), 32'hC));
    directed.push_back(exec_req(make_op(7'h00, F3_SLTU, 5'd8, 5'd2, 5'd31), 32'h10));
    directed.push_back(exec_req(make_op(7'h00, F3_XOR, 5'd9, 5'd1, 5'd3), 32'h14));
    directed.push_back(exec_req(make_op(7'h00, F3_SRL_SRA, 5'd10, 5'd2, 5'd1), 32'h18));
    directed.push_back(exec_req(make_op(7'h20, F3_SRL_SRA, 5'd11, 5'd2, 5'd1), 32'h1C));
    directed.push_back(exec_req(make_op(7'h00, F3_OR, 5'd12, 5'd2, 5'd31), 32'h20));
    directed.push_back(exec_req(make_op(7'h00, F3_AND, 5'd13, 5'd1, 5'd3), 32'h24));
    // Back-to-back dependent instructions exercise the write bypass.
    directed.push_back(exec_req(make_op(7'h00, F3_ADD_SUB, 5'd14, 5'd4, 5'd4), 32'h28));
    directed.push_back(exec_req(make_op(7'h00, F3_ADD_SUB, 5'd15, 5'd14, 5'd14), 32'h2C));
    // Destination x0 is discarded; source x0 reads zero.
    directed.push_back(exec_req(make_op(7'h00, F3_ADD_SUB, 5'd0, 5'd1, 5'd1), 32'h30));
    directed.push_back(exec_req(make_op(7'h20, F3_ADD_SUB, 5'd16, 5'd0, 5'd31), 32'h34));
    // Funct7 bits other than bit 30 are ignored, and bit 30 means nothing
    // for xor.
    directed.push_back(exec_req(make_op(7'h7F, F3_XOR, 5'd17, 5'd1, 5'd2), 32'h38));
    directed.push_back(exec_req(make_op(7'h01, F3_ADD_SUB, 5'd18, 5'd3, 5'd31), 32'h3C));
    // Opcodes other than OP, with the program counter wrapping past the top.
    directed.push_back(exec_req(32'h0010_8093, 32'hFFFF_FFFC));
    directed.push_back(exec_req(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(exec_req(32'h0000_0000, 32'h0));
    directed.push_back(preload_req(5'd31, 32'h0000_0000));
    foreach (directed[i]) send_request(directed[i]);
    wait_drained();

    // First random phase opens with a long result-side hold-off while the
    // sender keeps offering, so the pipeline fills and stalls its input.
    hold_off_cycles = 150;
    run_random_phase(610, 29, 62);
    wait_drained();
    run_random_phase(610, 62, 29);
    wait_drained();
    run_random_phase(610, 0, 0);
    wait_drained();

    // A few more cycles to catch any result the block should not produce.
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

### files.f
rtl/rae_pkg.sv
rtl/rae_ram.sv
rtl/rae_regfile.sv
rtl/rae_alu.sv
rtl/rv32i_register_alu_execute.sv
dv/rv32i_register_alu_execute_tb.sv
